/* hw/rtl/rmq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types and constants of the rotation matrix to quaternion unit
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int IN_W  = 18;
   localparam int OUT_W = 18;
   localparam int NUM_W = 19;
   localparam int SUM_W = 20;

   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_X     = 2'd1,
      BR_Y     = 2'd2,
      BR_Z     = 2'd3
   } branch_type;

   typedef struct packed {
      logic       valid;
      branch_type branch;
   } stage_ctl_type;

endpackage

/* hw/rtl/rmq_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_front
// diagonal combinations, branch pick, radicand and numerator magnitudes
// ----------------------------------------------------------------------------
module rmq_front
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int RAD_W     = 21
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         en,
   input  wire                         in_valid,
   input  wire  [9*IN_W-1:0]           in_data,
   output stage_ctl_type               ctl,
   output logic [RAD_W-1:0]            rad,
   output logic [3*NUM_W-1:0]          mag,
   output logic [2:0]                  sign
);

   logic signed [IN_W-1:0]  m [9];
   logic signed [SUM_W-1:0] e [9];
   logic signed [SUM_W-1:0] tr, t1, t2, t3, comb;
   logic signed [RAD_W:0]   rad_s;
   logic signed [NUM_W-1:0] n [3];
   logic [NUM_W-1:0]        mag_c [3];
   branch_type              branch_c;

   stage_ctl_type           ctl_ff, ctl_in;
   logic [RAD_W-1:0]        rad_ff, rad_in;
   logic [3*NUM_W-1:0]      mag_ff, mag_in;
   logic [2:0]              sign_ff, sign_in;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         m[k] = in_data[k*IN_W +: IN_W];
         e[k] = SUM_W'(m[k]);
      end
      tr = e[0] + e[4] + e[8];
      t1 = e[0] - e[4] - e[8];
      t2 = e[4] - e[0] - e[8];
      t3 = e[8] - e[0] - e[4];
      if (tr > 0) begin
         branch_c = BR_TRACE;
         comb     = tr;
         n[0] = NUM_W'(m[7]) - NUM_W'(m[5]);
         n[1] = NUM_W'(m[2]) - NUM_W'(m[6]);
         n[2] = NUM_W'(m[3]) - NUM_W'(m[1]);
      end else if (t1 > t2 && t1 > t3) begin
         branch_c = BR_X;
         comb     = t1;
         n[0] = NUM_W'(m[7]) - NUM_W'(m[5]);
         n[1] = NUM_W'(m[3]) + NUM_W'(m[1]);
         n[2] = NUM_W'(m[6]) + NUM_W'(m[2]);
      end else if (t2 > t1 && t2 > t3) begin
         branch_c = BR_Y;
         comb     = t2;
         n[0] = NUM_W'(m[2]) - NUM_W'(m[6]);
         n[1] = NUM_W'(m[3]) + NUM_W'(m[1]);
         n[2] = NUM_W'(m[7]) + NUM_W'(m[5]);
      end else begin
         branch_c = BR_Z;
         comb     = t3;
         n[0] = NUM_W'(m[3]) - NUM_W'(m[1]);
         n[1] = NUM_W'(m[6]) + NUM_W'(m[2]);
         n[2] = NUM_W'(m[7]) + NUM_W'(m[5]);
      end
      rad_s = ((RAD_W+1)'(1) <<< FRAC_BITS) + (RAD_W+1)'(comb);
      rad_in = rad_s[RAD_W] ? '0 : rad_s[RAD_W-1:0];
      for (int k = 0; k < 3; k++) begin
         mag_c[k] = n[k][NUM_W-1] ? NUM_W'(-n[k]) : NUM_W'(n[k]);
         mag_in[k*NUM_W +: NUM_W] = mag_c[k];
         sign_in[k] = n[k][NUM_W-1];
      end
      ctl_in.valid  = in_valid;
      ctl_in.branch = branch_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff.branch <= ctl_in.branch;
         rad_ff        <= rad_in;
         mag_ff        <= mag_in;
         sign_ff       <= sign_in;
      end
   end

   assign ctl  = ctl_ff;
   assign rad  = rad_ff;
   assign mag  = mag_ff;
   assign sign = sign_ff;

endmodule
`default_nettype wire

/* hw/rtl/rmq_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module rmq_sqrt #(
   parameter int N      = 19,
   parameter int SIDE_W = 62
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               en,
   input  wire               in_valid,
   input  wire  [2*N-1:0]    x,
   input  wire  [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [N-1:0]      root,
   output logic [SIDE_W-1:0] side_out
);

   logic [N-1:0]      v_ff;
   logic [2*N-1:0]    x_ff    [N];
   logic [N+1:0]      rem_ff  [N];
   logic [N-1:0]      root_ff [N];
   logic [SIDE_W-1:0] side_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic              v_prev;
      logic [2*N-1:0]    x_prev;
      logic [N+1:0]      rem_prev, rem_sh, trial, rem_in;
      logic [N-1:0]      root_prev, root_in;
      logic [SIDE_W-1:0] side_prev;

      if (i == 0) begin : g_first
         assign v_prev    = in_valid;
         assign x_prev    = x;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign side_prev = side_in;
      end else begin : g_next
         assign v_prev    = v_ff[i-1];
         assign x_prev    = x_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      always_comb begin
         rem_sh = {rem_prev[N-1:0], x_prev[2*(N-1-i) +: 2]};
         trial  = {root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[N-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_prev;
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign root      = root_ff[N-1];
   assign side_out  = side_ff[N-1];

endmodule
`default_nettype wire

/* hw/rtl/rmq_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_div
// three-lane pipelined restoring divider with a shared divisor
// ----------------------------------------------------------------------------
module rmq_div #(
   parameter int DW     = 35,
   parameter int DEN_W  = 20,
   parameter int SIDE_W = 23
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               en,
   input  wire               in_valid,
   input  wire  [3*DW-1:0]   dividend,
   input  wire  [DEN_W-1:0]  den,
   input  wire  [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [3*DW-1:0]   quot,
   output logic [SIDE_W-1:0] side_out
);

   logic [DW-1:0]     v_ff;
   logic [3*DW-1:0]   d_ff    [DW];
   logic [3*DW-1:0]   q_ff    [DW];
   logic [3*DEN_W-1:0] rem_ff [DW];
   logic [DEN_W-1:0]  den_ff  [DW];
   logic [SIDE_W-1:0] side_ff [DW];

   for (genvar i = 0; i < DW; i++) begin : g_stage
      logic               v_prev;
      logic [3*DW-1:0]    d_prev, q_prev, q_in;
      logic [3*DEN_W-1:0] rem_prev, rem_in;
      logic [DEN_W-1:0]   den_prev;
      logic [SIDE_W-1:0]  side_prev;
      logic [DEN_W:0]     rem_sh [3];

      if (i == 0) begin : g_first
         assign v_prev    = in_valid;
         assign d_prev    = dividend;
         assign q_prev    = '0;
         assign rem_prev  = '0;
         assign den_prev  = den;
         assign side_prev = side_in;
      end else begin : g_next
         assign v_prev    = v_ff[i-1];
         assign d_prev    = d_ff[i-1];
         assign q_prev    = q_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign den_prev  = den_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      always_comb begin
         for (int k = 0; k < 3; k++) begin
            rem_sh[k] = {rem_prev[k*DEN_W +: DEN_W], d_prev[k*DW + DW-1-i]};
            if (rem_sh[k] >= {1'b0, den_prev}) begin
               rem_in[k*DEN_W +: DEN_W] = DEN_W'(rem_sh[k] - {1'b0, den_prev});
               q_in[k*DW +: DW] = {q_prev[k*DW +: DW-1], 1'b1};
            end else begin
               rem_in[k*DEN_W +: DEN_W] = rem_sh[k][DEN_W-1:0];
               q_in[k*DW +: DW] = {q_prev[k*DW +: DW-1], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[i]    <= d_prev;
            q_ff[i]    <= q_in;
            rem_ff[i]  <= rem_in;
            den_ff[i]  <= den_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[DW-1];
   assign quot      = q_ff[DW-1];
   assign side_out  = side_ff[DW-1];

endmodule
`default_nettype wire

/* hw/rtl/rotation_matrix_to_quaternion_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// converts a 3x3 rotation matrix to a unit quaternion, largest-diagonal method
// ----------------------------------------------------------------------------
// One matrix is taken per cycle and one quaternion leaves per cycle while the
// output is not held. The pipeline is one input stage, a square root that
// resolves one root bit per stage (SQ_N = 19 stages at FRAC_BITS = 16), a
// three-lane divider that resolves one quotient bit per stage (35 stages at
// FRAC_BITS = 16) and an output register.
// The whole pipeline holds while a result waits on rsp_tready; req_tready
// follows that same hold.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [167:0] req_tdata,  // m_row0_col0 .. m_row2_col2, 18 bits each, row major
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [71:0]  rsp_tdata,  // quat_w, quat_x, quat_y, quat_z, 18 bits each
   output logic [2:0]   rsp_tuser   // branch_used [1:0], degenerate [2]
);

   localparam int RAD_W  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;
   localparam int SQ_N   = (RAD_W + FRAC_BITS + 1) / 2;
   localparam int MAIN_W = SQ_N - 1;
   localparam int DEN_W  = MAIN_W + 2;
   localparam int DW     = NUM_W + FRAC_BITS;
   localparam int SQ_SW  = 2 + 3 + 3*NUM_W;
   localparam int DV_SW  = 2 + 3 + MAIN_W;
   localparam int VAL_W  = FRAC_BITS + 2;
   localparam int EXT_W  = (VAL_W > OUT_W) ? VAL_W : OUT_W;

   logic                en;
   stage_ctl_type       f_ctl;
   logic [RAD_W-1:0]    f_rad;
   logic [3*NUM_W-1:0]  f_mag;
   logic [2:0]          f_sign;

   logic [2*SQ_N-1:0]   sq_x;
   logic                sq_valid;
   logic [SQ_N-1:0]     sq_root;
   logic [SQ_SW-1:0]    sq_side;
   logic [MAIN_W-1:0]   main_c;
   logic [3*DW-1:0]     dv_dividend;

   logic                dv_valid;
   logic [3*DW-1:0]     dv_quot;
   logic [DV_SW-1:0]    dv_side;
   logic [MAIN_W-1:0]   dv_main;
   logic [2:0]          dv_sign;
   branch_type          dv_branch;

   logic [DW-1:0]           lane_q;
   logic [FRAC_BITS:0]      lane_mag;
   logic signed [VAL_W-1:0] lane_val [3];
   logic signed [VAL_W-1:0] main_val;
   logic signed [VAL_W-1:0] comp [4];
   logic signed [EXT_W-1:0] comp_ext;
   logic                    degen_c;

   logic                valid_ff;
   logic [71:0]         data_ff, data_in;
   logic [2:0]          user_ff, user_in;

   assign en         = !valid_ff || rsp_tready;
   assign req_tready = en;

   rmq_front #(
      .FRAC_BITS (FRAC_BITS),
      .RAD_W     (RAD_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_data  (req_tdata[9*IN_W-1:0]),
      .ctl      (f_ctl),
      .rad      (f_rad),
      .mag      (f_mag),
      .sign     (f_sign)
   );

   assign sq_x = (2*SQ_N)'({f_rad, {FRAC_BITS{1'b0}}});

   rmq_sqrt #(
      .N      (SQ_N),
      .SIDE_W (SQ_SW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_ctl.valid),
      .x         (sq_x),
      .side_in   ({f_ctl.branch, f_sign, f_mag}),
      .out_valid (sq_valid),
      .root      (sq_root),
      .side_out  (sq_side)
   );

   assign main_c = sq_root[SQ_N-1:1];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dv_dividend[k*DW +: DW] = {sq_side[k*NUM_W +: NUM_W], {FRAC_BITS{1'b0}}};
      end
   end

   rmq_div #(
      .DW     (DW),
      .DEN_W  (DEN_W),
      .SIDE_W (DV_SW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .dividend  (dv_dividend),
      .den       ({main_c, 2'b00}),
      .side_in   ({sq_side[SQ_SW-1 -: 5], main_c}),
      .out_valid (dv_valid),
      .quot      (dv_quot),
      .side_out  (dv_side)
   );

   assign dv_main   = dv_side[MAIN_W-1:0];
   assign dv_sign   = dv_side[MAIN_W +: 3];
   assign dv_branch = branch_type'(dv_side[DV_SW-1 -: 2]);

   always_comb begin
      degen_c  = (dv_main == '0);
      main_val = (MAIN_W'(dv_main) > (MAIN_W'(1) << FRAC_BITS))
                 ? (VAL_W'(1) <<< FRAC_BITS) : VAL_W'(dv_main);
      for (int k = 0; k < 3; k++) begin
         lane_q   = dv_quot[k*DW +: DW];
         lane_mag = (lane_q > (DW'(1) << FRAC_BITS))
                    ? ((FRAC_BITS+1)'(1) << FRAC_BITS) : lane_q[FRAC_BITS:0];
         lane_val[k] = dv_sign[k] ? -VAL_W'(lane_mag) : VAL_W'(lane_mag);
      end
      case (dv_branch)
         BR_TRACE: begin
            comp[0] = main_val;    comp[1] = lane_val[0];
            comp[2] = lane_val[1]; comp[3] = lane_val[2];
         end
         BR_X: begin
            comp[0] = lane_val[0]; comp[1] = main_val;
            comp[2] = lane_val[1]; comp[3] = lane_val[2];
         end
         BR_Y: begin
            comp[0] = lane_val[0]; comp[1] = lane_val[1];
            comp[2] = main_val;    comp[3] = lane_val[2];
         end
         default: begin
            comp[0] = lane_val[0]; comp[1] = lane_val[1];
            comp[2] = lane_val[2]; comp[3] = main_val;
         end
      endcase
      for (int k = 0; k < 4; k++) begin
         comp_ext = EXT_W'(comp[k]);
         data_in[k*OUT_W +: OUT_W] = degen_c ? '0 : comp_ext[OUT_W-1:0];
      end
      user_in = {degen_c, dv_branch};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
         user_ff <= user_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule
`default_nettype wire

/* hw/rtl/rmq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_checker
// port-level checks of the rotation matrix to quaternion unit
// ----------------------------------------------------------------------------
module rmq_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [71:0]  rsp_tdata,
   input wire [2:0]   rsp_tuser
);

   // held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // input side holds exactly when a result is held
   assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output hold");

   // degenerate results carry an all-zero quaternion
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tdata == 72'd0)
      else $error("degenerate result not zero");

   // nothing leaves the pipeline right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

/* verif/rotation_matrix_to_quaternion_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit_test
// self-checking testbench of the rotation matrix to quaternion unit
// ----------------------------------------------------------------------------
// Directed matrices cover identity, half turns about each axis, branch ties
// and out-of-range elements. Random rotation-like and fully random matrices
// follow. Every result is compared field by field against a fixed-point
// predictor, with random gaps and stalls on both sides, one long receiver
// hold and four full drains.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit_test
   import rmq_pkg::*;
();

   localparam int FRAC = 16;
   localparam int ONE = 65536;
   localparam int LATENCY = 2 + 19 + 19 + FRAC;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic signed [17:0] w, x, y, z;
      branch_type branch;
      logic degenerate;
   } quat_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [167:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic [2:0] rsp_tuser;

   quat_result_type expected_quats[$];
   int error_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int idle_cycles = 0;
   int branch_seen[4] = '{0, 0, 0, 0};
   int degenerate_seen = 0;
   bit hold_receiver = 0;
   bit random_stall = 1;
   bit rsp_accepted = 0;
   int rsp_wait = 0;

   rotation_matrix_to_quaternion_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint root_floor(longint v);
      longint r;
      longint b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > ONE) return ONE;
      if (v < -ONE) return -ONE;
      return v;
   endfunction

   function automatic longint scaled_quotient(longint num, longint root);
      longint mag;
      longint q;
      mag = (num < 0 ? -num : num) <<< FRAC;
      q = mag / (4 * root);
      if (q > ONE) q = ONE;
      return num < 0 ? -q : q;
   endfunction

   function automatic quat_result_type predict_quat(logic [167:0] mat);
      longint e[9];
      longint tr, t1, t2, t3, comb, rad, root;
      longint q[4];
      longint n[3];
      int idx[3];
      int br;
      quat_result_type res;
      for (int i = 0; i < 9; i++) e[i] = longint'($signed(mat[i*18 +: 18]));
      tr = e[0] + e[4] + e[8];
      t1 = e[0] - e[4] - e[8];
      t2 = -e[0] + e[4] - e[8];
      t3 = -e[0] - e[4] + e[8];
      if (tr > 0) begin
         br = BR_TRACE; comb = tr;
         n = '{e[7] - e[5], e[2] - e[6], e[3] - e[1]}; idx = '{1, 2, 3};
      end else if (t1 > t2 && t1 > t3) begin
         br = BR_X; comb = t1;
         n = '{e[7] - e[5], e[3] + e[1], e[6] + e[2]}; idx = '{0, 2, 3};
      end else if (t2 > t1 && t2 > t3) begin
         br = BR_Y; comb = t2;
         n = '{e[2] - e[6], e[3] + e[1], e[7] + e[5]}; idx = '{0, 1, 3};
      end else begin
         br = BR_Z; comb = t3;
         n = '{e[3] - e[1], e[6] + e[2], e[7] + e[5]}; idx = '{0, 1, 2};
      end
      rad = ONE + comb;
      if (rad < 0) rad = 0;
      root = root_floor(rad <<< FRAC) >>> 1;
      q = '{0, 0, 0, 0};
      if (root != 0) begin
         q[br] = clamp_unit(root);
         for (int i = 0; i < 3; i++) q[idx[i]] = scaled_quotient(n[i], root);
      end
      res.w = q[0][17:0];
      res.x = q[1][17:0];
      res.y = q[2][17:0];
      res.z = q[3][17:0];
      res.branch = branch_type'(br[1:0]);
      res.degenerate = (root == 0);
      return res;
   endfunction

   task automatic send_matrix(input logic signed [17:0] m[9]);
      logic [167:0] packed_mat;
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      packed_mat = '0;
      for (int i = 0; i < 9; i++) packed_mat[i*18 +: 18] = m[i];
      req_tdata <= packed_mat;
      req_tvalid <= 1;
      expected_quats.insert(expected_quats.size(), predict_quat(packed_mat));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic finish_sending();
      req_tvalid <= 0;
   endtask

   task automatic wait_drained();
      finish_sending();
      while (expected_quats.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [17:0] rand_element();
      case ($urandom_range(0, 5))
         0: return 18'(ONE);
         1: return 18'(-ONE);
         2: return 18'sd0;
         3: return 18'($urandom_range(0, 2 * ONE) - ONE);
         4: return 18'($urandom_range(0, 262143));
         default: return 18'($urandom_range(0, 4096) - 2048);
      endcase
   endfunction

   task automatic test_directed();
      logic signed [17:0] m[9];
      m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}; send_matrix(m);
      m = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}; send_matrix(m);
      m = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}; send_matrix(m);
      m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}; send_matrix(m);
      m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}; send_matrix(m);
      m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);
      m = '{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE}; send_matrix(m);
      m = '{ONE, 0, 0, 0, 0, -ONE, 0, ONE, 0}; send_matrix(m);
      m = '{0, 0, ONE, 0, ONE, 0, -ONE, 0, 0}; send_matrix(m);
      m = '{-131072, 0, 0, 0, -131072, 0, 0, 0, -131072}; send_matrix(m);
      m = '{131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071};
      send_matrix(m);
      m = '{-131072, -131072, -131072, -131072, 131071, -131072, -131072, -131072,
            -131072};
      send_matrix(m);
      m = '{-ONE, 5, -7, 9, -ONE, 11, 3, -13, -ONE}; send_matrix(m);
      m = '{-32768, 131071, -131072, 131071, -32768, 131071, -131072, 131071, ONE};
      send_matrix(m);
      m = '{0, 1, 2, 3, -1, 4, 5, 6, 0}; send_matrix(m);
      m = '{-ONE + 1, 100, 0, 0, -ONE + 1, 0, 0, 0, -ONE + 1}; send_matrix(m);
      m = '{-21845, 0, 0, 0, -21845, 0, 0, 0, -21846}; send_matrix(m);
      m = '{1, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);
      wait_drained();
   endtask

   task automatic test_random_matrices(input int count);
      logic signed [17:0] m[9];
      int angle_sign;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 3) != 0) begin
            // near-rotation: diagonal sign pattern of a rotation, off-diagonals anywhere in [-ONE, ONE]
            angle_sign = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++) m[i] = 18'($urandom_range(0, 2 * ONE) - ONE);
            m[0] = (angle_sign == 1 || angle_sign == 0) ? 18'($urandom_range(0, ONE))
                                                         : 18'(-$urandom_range(0, ONE));
            m[4] = (angle_sign == 2 || angle_sign == 0) ? 18'($urandom_range(0, ONE))
                                                         : 18'(-$urandom_range(0, ONE));
            m[8] = (angle_sign == 3 || angle_sign == 0) ? 18'($urandom_range(0, ONE))
                                                         : 18'(-$urandom_range(0, ONE));
         end else begin
            for (int i = 0; i < 9; i++) m[i] = rand_element();
         end
         send_matrix(m);
      end
   endtask

   task automatic test_receiver_hold();
      hold_receiver = 1;
      fork
         test_random_matrices(100);
         begin
            repeat (300) @(negedge clock);
            hold_receiver = 0;
         end
      join
      wait_drained();
   endtask

   always @(posedge clock) begin
      rsp_accepted <= rsp_tvalid && rsp_tready;
   end

   always @(negedge clock) begin
      if (reset || hold_receiver) begin
         rsp_tready <= 0;
      end else if (!random_stall) begin
         rsp_tready <= 1;
      end else begin
         if (rsp_accepted) rsp_wait = $urandom_range(0, 3);
         if (rsp_wait != 0) begin
            rsp_tready <= 0;
            rsp_wait--;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      quat_result_type exp_q;
      quat_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.w = rsp_tdata[17:0];
         got.x = rsp_tdata[35:18];
         got.y = rsp_tdata[53:36];
         got.z = rsp_tdata[71:54];
         got.branch = branch_type'(rsp_tuser[1:0]);
         got.degenerate = rsp_tuser[2];
         if (expected_quats.size() == 0) begin
            $error("unexpected transaction: w %0d", got.w);
            error_count++;
         end else begin
            exp_q = expected_quats.pop_front();
            checked_count++;
            branch_seen[got.branch]++;
            if (got.degenerate) degenerate_seen++;
            if (got.w !== exp_q.w) begin
               $error("quat_w expected %0d actual %0d", exp_q.w, got.w); error_count++;
            end
            if (got.x !== exp_q.x) begin
               $error("quat_x expected %0d actual %0d", exp_q.x, got.x); error_count++;
            end
            if (got.y !== exp_q.y) begin
               $error("quat_y expected %0d actual %0d", exp_q.y, got.y); error_count++;
            end
            if (got.z !== exp_q.z) begin
               $error("quat_z expected %0d actual %0d", exp_q.z, got.z); error_count++;
            end
            if (got.branch !== exp_q.branch) begin
               $error("branch_used expected %0d actual %0d", exp_q.branch, got.branch);
               error_count++;
            end
            if (got.degenerate !== exp_q.degenerate) begin
               $error("degenerate expected %0d actual %0d", exp_q.degenerate,
                      got.degenerate);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d transactions pending", expected_quats.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_receiver_hold();
      test_random_matrices(700);
      wait_drained();
      random_stall = 0;
      test_random_matrices(300);
      random_stall = 1;
      test_random_matrices(400);
      wait_drained();
      repeat (LATENCY + 10) @(negedge clock);
      $display("%0d matrices sent, %0d quaternions checked, branches %0d/%0d/%0d/%0d",
               sent_count, checked_count, branch_seen[0], branch_seen[1],
               branch_seen[2], branch_seen[3]);
      $display("%0d degenerate results, %0d mismatches", degenerate_seen, error_count);
      if (error_count == 0 && expected_quats.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
